// File: src/cds_pkg.sv
// Shared types, constants and tables for the calendar date stepper.
// Holds the microcode word layout, the microprogram ROM and the month tables.
// No dependencies.
package cds_pkg;

	localparam int YEAR_W  = 12;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int DELTA_W = 6;
	localparam int LEN_W   = 5;
	localparam int WDAY_W  = 3;
	localparam int CELL_W  = 6;

	localparam logic [YEAR_W-1:0] LOWEST_YEAR_RST  = 12'd2000;
	localparam logic [YEAR_W-1:0] HIGHEST_YEAR_RST = 12'd2099;

	localparam logic [MONTH_W-1:0] JAN = 4'd1;
	localparam logic [MONTH_W-1:0] FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MAR = 4'd3;
	localparam logic [MONTH_W-1:0] DEC = 4'd12;

	localparam logic [LEN_W-1:0] MONTH_DAYS [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};
	localparam logic [WDAY_W-1:0] MONTH_OFFSET [12] = '{
		3'd0, 3'd3, 3'd2, 3'd5, 3'd0, 3'd3,
		3'd5, 3'd1, 3'd4, 3'd6, 3'd2, 3'd4
	};

	// reciprocal constants: floor(x*R >> S) is exact over the operand range used
	localparam logic [12:0] RECIP_25  = 13'd5243;  // shift 17, x < 4096
	localparam logic [12:0] RECIP_100 = 13'd5243;  // shift 19, x < 8192
	localparam logic [13:0] RECIP_7   = 14'd9363;  // shift 16, x < 8192

	typedef enum logic [2:0] {
		OP_FETCH   = 3'd0,
		OP_NORM    = 3'd1,
		OP_LEAP_LD = 3'd2,
		OP_CHECK   = 3'd3,
		OP_WD1     = 3'd4,
		OP_WD2     = 3'd5,
		OP_WD3     = 3'd6
	} cds_op_t;

	typedef enum logic [2:0] {
		CND_NEXT   = 3'd0,
		CND_JUMP   = 3'd1,
		CND_FETCH  = 3'd2,
		CND_NORMAL = 3'd3,
		CND_OUT    = 3'd4
	} cds_cond_t;

	typedef logic [2:0] cds_uaddr_t;

	localparam cds_uaddr_t UA_FETCH = 3'd0;
	localparam cds_uaddr_t UA_NORM1 = 3'd1;
	localparam cds_uaddr_t UA_NORM2 = 3'd2;
	localparam cds_uaddr_t UA_WD1   = 3'd3;
	localparam cds_uaddr_t UA_WD2   = 3'd4;
	localparam cds_uaddr_t UA_WD3   = 3'd5;
	localparam cds_uaddr_t UA_LOAD  = 3'd6;
	localparam cds_uaddr_t UA_CHECK = 3'd7;

	typedef struct packed {
		cds_op_t    op;
		cds_cond_t  cond;
		cds_uaddr_t tgt;
	} cds_uword_t;

	typedef struct packed {
		cds_op_t op;
		logic    en;
	} cds_ctl_t;

	// microprogram
	function automatic cds_uword_t ucode(input cds_uaddr_t a);
		cds_uword_t w;
		case (a)
			UA_FETCH: w = '{op: OP_FETCH,   cond: CND_FETCH,  tgt: UA_LOAD};
			UA_NORM1: w = '{op: OP_NORM,    cond: CND_NORMAL, tgt: UA_WD1};
			UA_NORM2: w = '{op: OP_NORM,    cond: CND_NEXT,   tgt: UA_WD1};
			UA_WD1:   w = '{op: OP_WD1,     cond: CND_NEXT,   tgt: UA_WD2};
			UA_WD2:   w = '{op: OP_WD2,     cond: CND_NEXT,   tgt: UA_WD3};
			UA_WD3:   w = '{op: OP_WD3,     cond: CND_OUT,    tgt: UA_FETCH};
			UA_LOAD:  w = '{op: OP_LEAP_LD, cond: CND_NEXT,   tgt: UA_CHECK};
			UA_CHECK: w = '{op: OP_CHECK,   cond: CND_JUMP,   tgt: UA_WD1};
			default:  w = '{op: OP_FETCH,   cond: CND_FETCH,  tgt: UA_LOAD};
		endcase
		return w;
	endfunction

	// invalid month codes read as 31; callers qualify the month themselves
	function automatic logic [LEN_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [LEN_W-1:0] r;
		logic [MONTH_W-1:0] idx;
		idx = m - 4'd1;
		if (m == FEB && leap) begin
			r = 5'd29;
		end else if (m >= JAN && m <= DEC) begin
			r = MONTH_DAYS[idx];
		end else begin
			r = 5'd31;
		end
		return r;
	endfunction

endpackage

// File: src/cds_if.sv
// Channel interfaces of the calendar date stepper: command and response.
// Valid/ready handshake with the payload alongside. Depends on cds_pkg.
interface cds_cmd_if;
	logic                              valid;
	logic                              ready;
	logic                              opcode;
	logic signed [cds_pkg::DELTA_W-1:0] day_delta;
	logic [cds_pkg::YEAR_W-1:0]        load_year;
	logic [cds_pkg::MONTH_W-1:0]       load_month;
	logic [cds_pkg::DAY_W-1:0]         load_day;

	modport source(output valid, opcode, day_delta, load_year, load_month, load_day,
		input ready);
	modport sink(input valid, opcode, day_delta, load_year, load_month, load_day,
		output ready);
endinterface

interface cds_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [cds_pkg::YEAR_W-1:0]   cur_year;
	logic [cds_pkg::MONTH_W-1:0]  cur_month;
	logic [cds_pkg::DAY_W-1:0]    cur_day;
	logic [cds_pkg::LEN_W-1:0]    month_length;
	logic [cds_pkg::WDAY_W-1:0]   first_weekday;
	logic [cds_pkg::CELL_W-1:0]   grid_cell;
	logic                         load_rejected;

	modport source(output valid, cur_year, cur_month, cur_day, month_length,
		first_weekday, grid_cell, load_rejected, input ready);
	modport sink(input valid, cur_year, cur_month, cur_day, month_length,
		first_weekday, grid_cell, load_rejected, output ready);
endinterface

// File: src/cds_datapath.sv
// Datapath of the calendar date stepper: date registers, day accumulator,
// leap and weekday arithmetic, result registers. Driven one op per cycle,
// unless stalled, by the top-level microcode sequencer. Depends on cds_pkg.
module cds_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cds_pkg::cds_ctl_t                 ctl,
	input  logic [cds_pkg::YEAR_W-1:0]        lowest_year,
	input  logic [cds_pkg::YEAR_W-1:0]        highest_year,
	input  logic signed [cds_pkg::DELTA_W-1:0] day_delta,
	input  logic [cds_pkg::YEAR_W-1:0]        load_year,
	input  logic [cds_pkg::MONTH_W-1:0]       load_month,
	input  logic [cds_pkg::DAY_W-1:0]         load_day,
	output logic                              acc_ok,
	output logic [cds_pkg::YEAR_W-1:0]        cur_year,
	output logic [cds_pkg::MONTH_W-1:0]       cur_month,
	output logic [cds_pkg::DAY_W-1:0]         cur_day,
	output logic [cds_pkg::LEN_W-1:0]         month_length,
	output logic [cds_pkg::WDAY_W-1:0]        first_weekday,
	output logic [cds_pkg::CELL_W-1:0]        grid_cell,
	output logic                              load_rejected
);

	// y % 4 == 0 and (y % 25 != 0 or y % 16 == 0)
	function automatic logic is_leap(input logic [cds_pkg::YEAR_W-1:0] y);
		logic [24:0] prod;
		logic [7:0]  q25;
		logic [11:0] m25;
		prod = 25'(y) * 25'(cds_pkg::RECIP_25);
		q25  = prod[24:17];
		m25  = {q25, 4'b0000} + {1'b0, q25, 3'b000} + {4'b0000, q25};
		return (y[1:0] == 2'b00) && ((m25 != y) || (y[3:0] == 4'b0000));
	endfunction

	logic [cds_pkg::YEAR_W-1:0]  year_q;
	logic [cds_pkg::MONTH_W-1:0] month_q;
	logic [cds_pkg::DAY_W-1:0]   day_q;
	logic                        leap_q;
	logic signed [6:0]           acc_q;
	logic                        rej_q;

	logic [cds_pkg::YEAR_W-1:0]  ld_year_q;
	logic [cds_pkg::MONTH_W-1:0] ld_month_q;
	logic [cds_pkg::DAY_W-1:0]   ld_day_q;
	logic                        ld_leap_q;

	logic [12:0] yy_q;
	logic [5:0]  q100_q;
	logic [12:0] s_q;

	logic [cds_pkg::YEAR_W-1:0]  cur_year_q;
	logic [cds_pkg::MONTH_W-1:0] cur_month_q;
	logic [cds_pkg::DAY_W-1:0]   cur_day_q;
	logic [cds_pkg::LEN_W-1:0]   month_length_q;
	logic [cds_pkg::WDAY_W-1:0]  first_weekday_q;
	logic [cds_pkg::CELL_W-1:0]  grid_cell_q;
	logic                        load_rejected_q;

	logic [cds_pkg::LEN_W-1:0]   len_cur;
	logic [cds_pkg::LEN_W-1:0]   len_prev;
	logic [cds_pkg::MONTH_W-1:0] prev_month;
	logic [cds_pkg::MONTH_W-1:0] next_month;
	logic                        acc_lo;
	logic                        acc_hi;
	logic [cds_pkg::YEAR_W-1:0]  leap_src;
	logic                        leap_calc;
	logic [cds_pkg::LEN_W-1:0]   ld_len;
	logic                        load_ok;
	logic signed [6:0]           acc_start;
	logic [12:0]                 yy;
	logic [25:0]                 prod100;
	logic [cds_pkg::MONTH_W-1:0] off_idx;
	logic [12:0]                 s_sum;
	logic [26:0]                 prod7;
	logic [9:0]                  q7;
	logic [12:0]                 rem7;
	logic [cds_pkg::WDAY_W-1:0]  wday;
	logic [cds_pkg::CELL_W-1:0]  grid_pos;

	assign len_cur    = cds_pkg::month_len(month_q, leap_q);
	assign prev_month = (month_q <= cds_pkg::JAN) ? cds_pkg::DEC : month_q - 4'd1;
	assign next_month = (month_q >= cds_pkg::DEC) ? cds_pkg::JAN : month_q + 4'd1;
	assign len_prev   = cds_pkg::month_len(prev_month, leap_q);
	assign acc_lo     = acc_q < 7'sd1;
	assign acc_hi     = acc_q > $signed({2'b00, len_cur});
	assign acc_ok     = !acc_lo && !acc_hi;

	// one leap unit, shared by the load check and the year refresh
	assign leap_src  = (ctl.op == cds_pkg::OP_LEAP_LD) ? ld_year_q : year_q;
	assign leap_calc = is_leap(leap_src);

	assign ld_len  = cds_pkg::month_len(ld_month_q, ld_leap_q);
	assign load_ok = (ld_month_q >= cds_pkg::JAN) && (ld_month_q <= cds_pkg::DEC)
		&& (ld_year_q >= lowest_year) && (ld_year_q <= highest_year)
		&& (ld_day_q != 5'd0) && (ld_day_q <= ld_len);

	assign acc_start = $signed({2'b00, day_q}) + $signed({day_delta[5], day_delta});

	// Sakamoto on year + 400, January and February count with the year before
	assign yy      = {1'b0, year_q} + 13'd400 - {12'd0, (month_q < cds_pkg::MAR)};
	assign prod100 = 26'(yy) * 26'(cds_pkg::RECIP_100);
	assign off_idx = month_q - 4'd1;
	assign s_sum   = yy_q + {2'b00, yy_q[12:2]} - {7'd0, q100_q} + {9'd0, q100_q[5:2]}
		+ {10'd0, cds_pkg::MONTH_OFFSET[off_idx]} + 13'd1;
	assign prod7   = 27'(s_q) * 27'(cds_pkg::RECIP_7);
	assign q7      = prod7[25:16];
	assign rem7    = s_q - ({3'b000, q7} * 13'd7);
	assign wday    = rem7[2:0];
	assign grid_pos = {3'b000, wday} + {1'b0, day_q} - 6'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q  <= cds_pkg::LOWEST_YEAR_RST;
			month_q <= cds_pkg::JAN;
			day_q   <= 5'd1;
			leap_q  <= 1'b1;
		end else if (ctl.en) begin
			case (ctl.op)
				cds_pkg::OP_NORM: begin
					if (acc_lo) begin
						month_q <= prev_month;
						if (month_q <= cds_pkg::JAN && year_q > lowest_year)
							year_q <= year_q - 12'd1;
					end else if (acc_hi) begin
						month_q <= next_month;
						if (month_q >= cds_pkg::DEC && year_q < highest_year)
							year_q <= year_q + 12'd1;
					end
				end
				cds_pkg::OP_CHECK: begin
					if (load_ok) begin
						year_q  <= ld_year_q;
						month_q <= ld_month_q;
					end
				end
				cds_pkg::OP_WD1: begin
					day_q  <= acc_q[4:0];
					leap_q <= leap_calc;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			case (ctl.op)
				cds_pkg::OP_FETCH: begin
					acc_q      <= acc_start;
					ld_year_q  <= load_year;
					ld_month_q <= load_month;
					ld_day_q   <= load_day;
					rej_q      <= 1'b0;
				end
				cds_pkg::OP_NORM: begin
					if (acc_lo)
						acc_q <= acc_q + $signed({2'b00, len_prev});
					else if (acc_hi)
						acc_q <= acc_q - $signed({2'b00, len_cur});
				end
				cds_pkg::OP_LEAP_LD: begin
					ld_leap_q <= leap_calc;
				end
				cds_pkg::OP_CHECK: begin
					acc_q <= load_ok ? $signed({2'b00, ld_day_q}) : $signed({2'b00, day_q});
					rej_q <= !load_ok;
				end
				cds_pkg::OP_WD1: begin
					yy_q   <= yy;
					q100_q <= prod100[24:19];
				end
				cds_pkg::OP_WD2: begin
					s_q <= s_sum;
				end
				cds_pkg::OP_WD3: begin
					cur_year_q      <= year_q;
					cur_month_q     <= month_q;
					cur_day_q       <= day_q;
					month_length_q  <= len_cur;
					first_weekday_q <= wday;
					grid_cell_q     <= grid_pos;
					load_rejected_q <= rej_q;
				end
				default: ;
			endcase
		end
	end

	assign cur_year      = cur_year_q;
	assign cur_month     = cur_month_q;
	assign cur_day       = cur_day_q;
	assign month_length  = month_length_q;
	assign first_weekday = first_weekday_q;
	assign grid_cell     = grid_cell_q;
	assign load_rejected = load_rejected_q;

endmodule

// File: src/calendar_date_stepper.sv
// Calendar date stepper top level: APB register port, microcode sequencer.
// Uses cds_pkg, cds_cmd_if / cds_rsp_if and cds_datapath.
//
// Usage: the cmd channel carries one transaction per command: opcode 0 steps
// the selected date by the signed day_delta, opcode 1 loads load_year,
// load_month and load_day. Each command yields one rsp transaction with the
// resulting date, its month length, the weekday of day 1 and the grid cell of
// the selected day; load_rejected flags an invalid load that left the date
// unchanged. The year window (lowest_year at 0x0, highest_year at 0x4) is
// to be written over APB by the user only while the block is idle; the
// block itself does not enforce this. One command is in flight at a time;
// the sequencer runs a fixed microprogram of up to six steps: fetch, one
// carry step (two for a step that crosses one or two months) or, for a load,
// a leap and a check step, then three weekday steps built around the
// reciprocal multipliers. The next command is taken as soon as the program
// returns to its fetch step, while the previous response may still wait.
// Reset sets the date to 1 January 2000 and the window to 2000..2099.
// A stalled receiver holds the response; the next command is still taken,
// but the sequencer then waits in its last step until the response
// register is free.
module calendar_date_stepper (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	cds_cmd_if.sink     cmd,
	cds_rsp_if.source   rsp
);

	localparam logic REG_LOWEST  = 1'b0;
	localparam logic REG_HIGHEST = 1'b1;

	logic [cds_pkg::YEAR_W-1:0] lowest_year_q;
	logic [cds_pkg::YEAR_W-1:0] highest_year_q;
	cds_pkg::cds_uaddr_t        pc_q;
	cds_pkg::cds_uaddr_t        pc_next;
	cds_pkg::cds_uword_t        uw;
	cds_pkg::cds_ctl_t          ctl;
	logic                       out_valid_q;
	logic                       acc_ok;
	logic                       wr_en;

	// config registers
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lowest_year_q  <= cds_pkg::LOWEST_YEAR_RST;
			highest_year_q <= cds_pkg::HIGHEST_YEAR_RST;
		end else if (wr_en) begin
			if (paddr[2] == REG_HIGHEST)
				highest_year_q <= pwdata[11:0];
			else
				lowest_year_q <= pwdata[11:0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		case (paddr[2])
			REG_LOWEST:  prdata = {20'd0, lowest_year_q};
			REG_HIGHEST: prdata = {20'd0, highest_year_q};
			default:     prdata = 32'd0;
		endcase
	end

	// sequencer
	assign uw = cds_pkg::ucode(pc_q);

	always_comb begin
		pc_next = 3'(pc_q + 3'd1);
		ctl.op  = uw.op;
		ctl.en  = 1'b1;
		case (uw.cond)
			cds_pkg::CND_NEXT: pc_next = 3'(pc_q + 3'd1);
			cds_pkg::CND_JUMP: pc_next = uw.tgt;
			cds_pkg::CND_FETCH: begin
				if (!cmd.valid) begin
					ctl.en  = 1'b0;
					pc_next = pc_q;
				end else if (cmd.opcode) begin
					pc_next = uw.tgt;
				end
			end
			cds_pkg::CND_NORMAL: begin
				if (acc_ok)
					pc_next = uw.tgt;
			end
			cds_pkg::CND_OUT: begin
				if (out_valid_q && !rsp.ready) begin
					ctl.en  = 1'b0;
					pc_next = pc_q;
				end else begin
					pc_next = uw.tgt;
				end
			end
			default: pc_next = cds_pkg::UA_FETCH;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= cds_pkg::UA_FETCH;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_next;
			if (ctl.en && uw.op == cds_pkg::OP_WD3)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	assign cmd.ready = (uw.cond == cds_pkg::CND_FETCH);
	assign rsp.valid = out_valid_q;

	cds_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.lowest_year  (lowest_year_q),
		.highest_year (highest_year_q),
		.day_delta    (cmd.day_delta),
		.load_year    (cmd.load_year),
		.load_month   (cmd.load_month),
		.load_day     (cmd.load_day),
		.acc_ok       (acc_ok),
		.cur_year     (rsp.cur_year),
		.cur_month    (rsp.cur_month),
		.cur_day      (rsp.cur_day),
		.month_length (rsp.month_length),
		.first_weekday(rsp.first_weekday),
		.grid_cell    (rsp.grid_cell),
		.load_rejected(rsp.load_rejected)
	);

endmodule
